// ----- src/fccp_pkg.sv -----
// ----------------------------------------------------------------------------
// fccp_pkg
// Shared types, constants and helper functions of the framed command
// checksum parser: frame markers, command list, result word layout.
// ----------------------------------------------------------------------------
package fccp_pkg;

   // frame markers
   localparam logic [7:0] STX_BYTE = 8'h02;
   localparam logic [7:0] ETX_BYTE = 8'h03;

   // frame size limits
   localparam int MAX_FRAME_BYTES = 256;
   localparam int MIN_FRAME_BYTES = 7;
   localparam int PARAM_CAP_INT   = (MAX_FRAME_BYTES - MIN_FRAME_BYTES) > 255 ?
                                    255 : (MAX_FRAME_BYTES - MIN_FRAME_BYTES);
   localparam logic [7:0] PARAM_CAP = 8'(PARAM_CAP_INT);

   // byte position counter
   localparam int POS_W = 9;
   localparam logic [POS_W-1:0] POS_MAX         = '1;
   localparam logic [POS_W-1:0] POS_CMD_FIRST   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_CMD_LAST    = POS_W'(3);
   localparam logic [POS_W-1:0] POS_SUM_FIRST   = POS_W'(4);
   localparam logic [POS_W-1:0] POS_SHORT_LIMIT = POS_W'(MIN_FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_PARAM_FIRST = POS_W'(MIN_FRAME_BYTES);

   // command list
   localparam int NUM_CMDS   = 22;
   localparam int CMD_CODE_W = 5;
   localparam logic [23:0] CMD_TABLE [NUM_CMDS] = '{
      "AMS", "AMF", "IR*", "OCV", "IDN", "SIZ", "STP", "FIN",
      "MAN", "SEN", "OUT", "BCR", "EMS", "RST", "REM", "ERR",
      "CLR", "REC", "LRM", "FRM", "STA", "DEV"
   };

   // output queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FRAMING  = 2'd1,
      STATUS_CHECKSUM = 2'd2,
      STATUS_UNKNOWN  = 2'd3
   } status_type;

   typedef enum logic {
      KIND_PARAM   = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type              result_kind;
      logic [7:0]            param_byte;
      status_type            status;
      logic [CMD_CODE_W-1:0] command_code;
      logic [7:0]            param_length;
      logic                  last;
   } result_type;

   typedef struct packed {
      logic                  hit;
      logic [CMD_CODE_W-1:0] code;
   } cmd_match_type;

   // upper-case hex character of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h37 + {4'd0, nib};
      end
      return ch;
   endfunction

   // first table entry equal to the command characters
   function automatic cmd_match_type cmd_lookup(input logic [23:0] chars);
      cmd_match_type m;
      m = '0;
      for (int i = NUM_CMDS - 1; i >= 0; i--) begin
         if (CMD_TABLE[i] == chars) begin
            m.hit  = 1'b1;
            m.code = CMD_CODE_W'(i);
         end
      end
      return m;
   endfunction

endpackage

// ----- src/fccp_if.sv -----
// ----------------------------------------------------------------------------
// fccp channel interfaces
// Valid/ready channels of the parser: message bytes in, result words out.
// ----------------------------------------------------------------------------
interface fccp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface fccp_rsp_if
   import fccp_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic                  result_kind;
   logic [7:0]            param_byte;
   logic [1:0]            status;
   logic [CMD_CODE_W-1:0] command_code;
   logic [7:0]            param_length;
   logic                  last;

   modport source (output valid, output result_kind, output param_byte, output status,
                   output command_code, output param_length, output last, input ready);
   modport sink   (input valid, input result_kind, input param_byte, input status,
                   input command_code, input param_length, input last, output ready);
endinterface

// ----- src/framed_command_checksum_parser_unit.sv -----
// ----------------------------------------------------------------------------
// framed_command_checksum_parser_unit
// Parses STX / command / parameters / hex checksum / ETX frames one byte per
// word and reports parameter bytes and a verdict per frame.
//
// Takes one message byte per cycle on req_bus; end_of_message marks the last
// byte. Parameter bytes come out on rsp_bus three bytes late, so checksum and
// ETX are never passed on; the last byte of a message yields a verdict word
// (status, command code, parameter length) and clears the frame state. Each
// accepted byte is handled in the cycle it is taken and its results go into
// a four-entry output queue, one word leaving per ready cycle. A byte is taken
// whenever at least two queue entries are free, so the sustained rate is one
// byte per cycle while the sink keeps up; only a final byte that still carries
// a parameter pushes two words. Reset clears the frame state.
// ----------------------------------------------------------------------------
module framed_command_checksum_parser_unit
   import fccp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   fccp_req_if.sink         req_bus,
   fccp_rsp_if.source       rsp_bus
);

   // frame state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             start_ok_ff, start_ok_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       dly_ff [3];
   logic [7:0]       dly_in [3];
   logic [23:0]      cmd_ff, cmd_in;
   logic [7:0]       pcount_ff, pcount_in;

   // output queue
   result_type       queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic             accept;
   logic             pop;
   logic             fin;
   logic [7:0]       b;
   logic [7:0]       leaving;
   logic             emit;
   logic [7:0]       sum_upd;
   logic [7:0]       pcount_upd;
   cmd_match_type    match;
   status_type       verdict_status;
   logic [CMD_CODE_W-1:0] verdict_code;
   result_type       param_res;
   result_type       verdict_res;
   result_type       res0;
   logic [1:0]       npush;
   logic [QPTR_W-1:0] tail_next1;

   // handshake
   assign req_bus.ready = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign accept        = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;
   assign fin           = req_bus.end_of_message;
   assign b             = req_bus.data_byte;
   assign leaving       = dly_ff[2];
   assign emit          = (pos_ff >= POS_PARAM_FIRST);

   // running sum and parameter count as seen by this byte
   assign sum_upd    = (pos_ff >= POS_SUM_FIRST) ? sum_ff + leaving : sum_ff;
   assign pcount_upd = (emit && pcount_ff < PARAM_CAP) ? pcount_ff + 8'd1 : pcount_ff;
   assign match      = cmd_lookup(cmd_ff);

   // verdict: framing first, then checksum, then command
   always_comb begin
      verdict_status = STATUS_OK;
      verdict_code   = '0;
      if (pos_ff < POS_SHORT_LIMIT || !start_ok_ff || b != ETX_BYTE) begin
         verdict_status = STATUS_FRAMING;
      end else if (dly_ff[1] != hex_char(sum_upd[7:4]) ||
                   dly_ff[0] != hex_char(sum_upd[3:0])) begin
         verdict_status = STATUS_CHECKSUM;
      end else if (!match.hit) begin
         verdict_status = STATUS_UNKNOWN;
      end else begin
         verdict_code = match.code;
      end
   end

   // result words of this byte
   always_comb begin
      param_res              = '0;
      param_res.result_kind  = KIND_PARAM;
      param_res.param_byte   = leaving;
      param_res.status       = STATUS_OK;
      param_res.last         = !fin;

      verdict_res              = '0;
      verdict_res.result_kind  = KIND_VERDICT;
      verdict_res.status       = verdict_status;
      verdict_res.command_code = verdict_code;
      verdict_res.param_length = pcount_upd;
      verdict_res.last         = 1'b1;

      res0 = emit ? param_res : verdict_res;
      case ({fin, emit})
         2'b00:   npush = 2'd0;
         2'b01:   npush = 2'd1;
         2'b10:   npush = 2'd1;
         2'b11:   npush = 2'd2;
         default: npush = 2'd0;
      endcase
      if (!accept) begin
         npush = 2'd0;
      end
   end

   // frame state next values
   always_comb begin
      pos_in      = pos_ff;
      start_ok_in = start_ok_ff;
      sum_in      = sum_ff;
      cmd_in      = cmd_ff;
      pcount_in   = pcount_ff;
      dly_in      = dly_ff;
      if (accept) begin
         if (fin) begin
            pos_in      = '0;
            start_ok_in = 1'b0;
            sum_in      = '0;
            cmd_in      = '0;
            pcount_in   = '0;
            dly_in      = '{default: 8'd0};
         end else begin
            if (pos_ff < POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
            if (pos_ff == '0) begin
               start_ok_in = (b == STX_BYTE);
            end
            if (pos_ff >= POS_CMD_FIRST && pos_ff <= POS_CMD_LAST) begin
               cmd_in = {cmd_ff[15:0], b};
            end
            sum_in    = sum_upd;
            pcount_in = pcount_upd;
            dly_in[2] = dly_ff[1];
            dly_in[1] = dly_ff[0];
            dly_in[0] = b;
         end
      end
   end

   // queue pointers
   always_comb begin
      tail_next1 = tail_ff + QPTR_W'(1);
      tail_in    = tail_ff + QPTR_W'(npush);
      head_in    = pop ? head_ff + QPTR_W'(1) : head_ff;
      count_in   = count_ff + QCNT_W'(npush) - QCNT_W'(pop);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         start_ok_ff <= 1'b0;
         sum_ff      <= '0;
         cmd_ff      <= '0;
         pcount_ff   <= '0;
         dly_ff      <= '{default: 8'd0};
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         pos_ff      <= pos_in;
         start_ok_ff <= start_ok_in;
         sum_ff      <= sum_in;
         cmd_ff      <= cmd_in;
         pcount_ff   <= pcount_in;
         dly_ff      <= dly_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         queue_ff[tail_ff] <= res0;
      end
      if (npush == 2'd2) begin
         queue_ff[tail_next1] <= verdict_res;
      end
   end

   // output word from the queue head
   assign rsp_bus.valid        = (count_ff != '0);
   assign rsp_bus.result_kind  = queue_ff[head_ff].result_kind;
   assign rsp_bus.param_byte   = queue_ff[head_ff].param_byte;
   assign rsp_bus.status       = queue_ff[head_ff].status;
   assign rsp_bus.command_code = queue_ff[head_ff].command_code;
   assign rsp_bus.param_length = queue_ff[head_ff].param_length;
   assign rsp_bus.last         = queue_ff[head_ff].last;

`ifndef SYNTH
   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("output queue overflow");

   // a final byte always restarts the frame
   assert property (@(posedge clock) disable iff (reset)
      accept && fin |=> pos_ff == '0 && pcount_ff == '0 && sum_ff == '0)
      else $error("frame state not cleared after final byte");

   // verdict words always close the item
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.result_kind == KIND_VERDICT |-> rsp_bus.last)
      else $error("verdict word without last");

   // a failed verdict carries command code zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != STATUS_OK |-> rsp_bus.command_code == '0)
      else $error("nonzero command code on failed frame");
`endif

endmodule
